@@ hw/rtl/clws_pkg.sv @@
// shared types, constants and command codes of the character lcd write sequencer
// no dependencies; all but the two interfaces refer to it by scoped names

package clws_pkg;

  // request kinds
  localparam logic [1:0] OP_TEXT = 2'd0;
  localparam logic [1:0] OP_CMD  = 2'd1;
  localparam logic [1:0] OP_MOVE = 2'd2;

  // configuration register indexes
  localparam logic CFG_BUS_MODE   = 1'b0;
  localparam logic CFG_BUSY_CHECK = 1'b1;

  // display geometry and wrap points
  localparam int unsigned LINE_LENGTH   = 16;
  localparam logic [5:0]  WRAP_LINE_TWO = 6'd16;
  localparam logic [5:0]  WRAP_CLEAR    = 6'd32;

  // display command bytes
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_LINE_ONE = 8'h80;
  localparam logic [7:0] CMD_LINE_TWO = 8'hC0;

  // nibble masks
  localparam logic [7:0] HI_NIBBLE = 8'hF0;

  // most bytes one request can cause
  localparam int unsigned MAX_BYTES = 3;

  typedef logic [5:0] count_t;
  typedef logic [1:0] nbytes_t;
  typedef logic [1:0] byte_idx_t;

  typedef struct packed {
    logic bus_mode;
    logic busy_check;
  } cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] byte_value;
    logic       start_of_text;
    logic [1:0] line_number;
    logic [7:0] column;
  } item_t;

  // list of bytes for one request, each with its register select
  typedef struct packed {
    nbytes_t                     nbytes;
    logic [MAX_BYTES-1:0]        rs;
    logic [MAX_BYTES-1:0][7:0]   data;
  } desc_t;

endpackage

@@ hw/rtl/clws_in_if.sv @@
// request channel of the character lcd write sequencer
// valid/ready handshake carrying one request per transfer; no dependencies

interface clws_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] byte_value;
  logic       start_of_text;
  logic [1:0] line_number;
  logic [7:0] column;

  modport source (output valid, operation, byte_value, start_of_text, line_number, column,
                  input ready);
  modport sink   (input valid, operation, byte_value, start_of_text, line_number, column,
                  output ready);
endinterface

@@ hw/rtl/clws_out_if.sv @@
// bus transfer channel of the character lcd write sequencer
// valid/ready handshake carrying one bus transfer per transfer; no dependencies

interface clws_out_if;
  logic       valid;
  logic       ready;
  logic       register_select;
  logic       read_not_write;
  logic [7:0] bus_value;
  logic       last_transfer;

  modport source (output valid, register_select, read_not_write, bus_value, last_transfer,
                  input ready);
  modport sink   (input valid, register_select, read_not_write, bus_value, last_transfer,
                  output ready);
endinterface

@@ hw/rtl/clws_decode.sv @@
// request decoder: turns one request into a list of up to three bytes
// and the next text count; depends on clws_pkg

module clws_decode (
  input  clws_pkg::item_t  item,
  input  clws_pkg::count_t count,
  output clws_pkg::desc_t  desc,
  output clws_pkg::count_t count_nxt
);

  clws_pkg::count_t cnt_inc;
  logic             move_ok;

  // count after this character, restarting on start of text
  assign cnt_inc = (item.start_of_text ? 6'd0 : count) + 6'd1;

  assign move_ok = (item.line_number <= 2'd1) &&
                   (item.column < 8'(clws_pkg::LINE_LENGTH));

  always_comb begin
    desc      = '0;
    count_nxt = count;
    unique case (item.operation)
      clws_pkg::OP_TEXT: begin
        desc.nbytes  = 2'd1;
        desc.rs[0]   = 1'b1;
        desc.data[0] = item.byte_value;
        count_nxt    = cnt_inc;
        if (cnt_inc == clws_pkg::WRAP_LINE_TWO) begin
          desc.nbytes  = 2'd2;
          desc.data[1] = clws_pkg::CMD_LINE_TWO;
        end else if (cnt_inc == clws_pkg::WRAP_CLEAR) begin
          desc.nbytes  = 2'd3;
          desc.data[1] = clws_pkg::CMD_CLEAR;
          desc.data[2] = clws_pkg::CMD_LINE_ONE;
          count_nxt    = '0;
        end
      end
      clws_pkg::OP_CMD: begin
        desc.nbytes  = 2'd1;
        desc.data[0] = item.byte_value;
      end
      clws_pkg::OP_MOVE: begin
        if (move_ok) begin
          desc.nbytes  = 2'd1;
          desc.data[0] = ((item.line_number == 2'd0) ? clws_pkg::CMD_LINE_ONE
                                                    : clws_pkg::CMD_LINE_TWO) | item.column;
        end
      end
      default: begin
        desc.nbytes = 2'd0;
      end
    endcase
  end

endmodule

@@ hw/rtl/clws_emit.sv @@
// transfer sequencer: holds one byte list, walks it one bus transfer per cycle
// unless out_ch stalls, into a registered output stage; depends on clws_pkg and clws_out_if

module clws_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  clws_pkg::cfg_t       cfg,
  input  logic                 load,
  input  clws_pkg::desc_t      desc_in,
  output logic                 slot_free,
  clws_out_if.source           out_ch
);

  logic                  desc_valid_r, desc_valid_nxt;
  clws_pkg::desc_t       desc_r;
  clws_pkg::byte_idx_t   byte_idx_r, byte_idx_nxt;
  logic                  phase_r, phase_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_rs_r, out_rnw_r, out_last_r;
  logic [7:0]            out_bus_r;

  logic                  fire;
  logic                  two_phase;
  logic                  xfer_last;
  logic [7:0]            cur_byte;
  logic                  cur_rs;
  logic                  x_rs, x_rnw;
  logic [7:0]            x_bus;

  // four-bit mode and busy-checked eight-bit mode take two transfers a byte
  assign two_phase = !cfg.bus_mode || cfg.busy_check;
  assign fire      = desc_valid_r && (!out_valid_r || out_ch.ready);
  assign cur_byte  = desc_r.data[byte_idx_r];
  assign cur_rs    = desc_r.rs[byte_idx_r];
  assign xfer_last = (byte_idx_r == (desc_r.nbytes - 2'd1)) && (!two_phase || phase_r);
  assign slot_free = !desc_valid_r || (fire && xfer_last);

  // compose the current transfer
  always_comb begin
    x_rs  = cur_rs;
    x_rnw = 1'b0;
    x_bus = cur_byte;
    if (!cfg.bus_mode) begin
      x_bus = phase_r ? {cur_byte[3:0], 4'b0000} : (cur_byte & clws_pkg::HI_NIBBLE);
    end else if (cfg.busy_check && !phase_r) begin
      x_rs  = 1'b0;
      x_rnw = 1'b1;
      x_bus = 8'h00;
    end
  end

  // sequencer position
  always_comb begin
    desc_valid_nxt = desc_valid_r;
    byte_idx_nxt   = byte_idx_r;
    phase_nxt      = phase_r;
    if (fire) begin
      if (two_phase && !phase_r) begin
        phase_nxt = 1'b1;
      end else begin
        phase_nxt    = 1'b0;
        byte_idx_nxt = byte_idx_r + 2'd1;
      end
      if (xfer_last) begin
        desc_valid_nxt = 1'b0;
      end
    end
    if (load) begin
      desc_valid_nxt = 1'b1;
      byte_idx_nxt   = '0;
      phase_nxt      = 1'b0;
    end
  end

  assign out_valid_nxt = fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_valid_r <= 1'b0;
      byte_idx_r   <= '0;
      phase_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      desc_valid_r <= desc_valid_nxt;
      byte_idx_r   <= byte_idx_nxt;
      phase_r      <= phase_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      desc_r <= desc_in;
    end
    if (fire) begin
      out_rs_r   <= x_rs;
      out_rnw_r  <= x_rnw;
      out_bus_r  <= x_bus;
      out_last_r <= xfer_last;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.register_select = out_rs_r;
  assign out_ch.read_not_write  = out_rnw_r;
  assign out_ch.bus_value       = out_bus_r;
  assign out_ch.last_transfer   = out_last_r;

endmodule

@@ hw/rtl/char_lcd_write_sequencer.sv @@
// top level of the character lcd write sequencer: configuration registers,
// text count and the decoder and sequencer; depends on clws_pkg, clws_in_if,
// clws_out_if, clws_decode and clws_emit
//
// usage
//   in_ch takes requests (text character, raw command, cursor move); out_ch
//   gives one bus transfer per transfer, last_transfer marking the final one
//   of a request. cfg_we/cfg_index/cfg_data write bus_mode (index 0) and busy
//   check enable (index 1); the user must write them only while the block is
//   idle, which the block does not enforce. a request is decoded on acceptance
//   into up to three bytes; each byte takes two transfers in four-bit mode or
//   busy-checked eight-bit mode and one otherwise, so a request causes up to
//   six transfers, one a cycle unless out_ch stalls. an accepted byte list is
//   loaded into the sequencer, which then moves its first transfer into the
//   output register. the next request is accepted in the cycle the current
//   one's last transfer moves into the output register, so requests follow
//   back to back; a request causing no transfer loads nothing into the
//   sequencer. the rate is set by the single sequencer walking the byte list.
//   reset clears the text count, sets four-bit mode with busy check on and
//   empties the pipeline. when the receiver stalls the output register holds
//   its transfer and the sequencer, then the request channel, stop.

module char_lcd_write_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  clws_in_if.sink    in_ch,
  clws_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_data
);

  clws_pkg::cfg_t   cfg_r;
  clws_pkg::count_t count_r;
  clws_pkg::count_t count_nxt;
  clws_pkg::item_t  item;
  clws_pkg::desc_t  desc;
  logic             slot_free;
  logic             accept;

  assign item.operation     = in_ch.operation;
  assign item.byte_value    = in_ch.byte_value;
  assign item.start_of_text = in_ch.start_of_text;
  assign item.line_number   = in_ch.line_number;
  assign item.column        = in_ch.column;

  assign in_ch.ready = slot_free;
  assign accept      = in_ch.valid && slot_free;

  clws_decode u_decode (
    .item      (item),
    .count     (count_r),
    .desc      (desc),
    .count_nxt (count_nxt)
  );

  clws_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .load      (accept && (desc.nbytes != 2'd0)),
    .desc_in   (desc),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

  // configuration registers and text count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bus_mode   <= 1'b0;
      cfg_r.busy_check <= 1'b1;
      count_r          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          clws_pkg::CFG_BUS_MODE:   cfg_r.bus_mode   <= cfg_data;
          clws_pkg::CFG_BUSY_CHECK: cfg_r.busy_check <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

endmodule

@@ verif/char_lcd_write_sequencer_test.sv @@
// self-checking testbench of the character lcd write sequencer: directed and random requests
// under every bus setting, predicted bus transfers compared field by field
// depends on clws_pkg, clws_in_if, clws_out_if and char_lcd_write_sequencer
`timescale 1ns / 1ps

module char_lcd_write_sequencer_test;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned IDLE_SETTLE = 8;
  localparam int unsigned HOLD_LEN = 150;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic       register_select;
    logic       read_not_write;
    logic [7:0] bus_value;
    logic       last_transfer;
  } lcd_xfer_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic cfg_data;

  clws_in_if  in_ch ();
  clws_out_if out_ch ();

  char_lcd_write_sequencer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predictor state and its copy of the registers
  logic             bus_mode_q;
  logic             busy_check_q;
  clws_pkg::count_t text_count_q;
  lcd_xfer_t        burst_q[$];
  lcd_xfer_t        expected_xfers[$];

  // run control and bookkeeping
  bit gap_en;
  bit stall_en;
  bit hold_req;
  int unsigned cycle_count;
  int unsigned hold_cycles;
  int mismatch_count;
  int requests_sent;
  int xfers_checked;
  int line_two_wraps;
  int clear_wraps;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic lcd_xfer_t make_xfer(logic rs, logic rnw, logic [7:0] bv);
    lcd_xfer_t x;
    x.register_select = rs;
    x.read_not_write  = rnw;
    x.bus_value       = bv;
    x.last_transfer   = 1'b0;
    return x;
  endfunction

  function automatic clws_pkg::item_t make_request(logic [1:0] op, logic [7:0] bv, logic sot,
                                                   logic [1:0] line, logic [7:0] col);
    clws_pkg::item_t r;
    r.operation     = op;
    r.byte_value    = bv;
    r.start_of_text = sot;
    r.line_number   = line;
    r.column        = col;
    return r;
  endfunction

  // one byte on the bus: two nibbles, or a whole byte with optional busy read
  task automatic queue_byte(input logic rs, input logic [7:0] b);
    if (bus_mode_q) begin
      if (busy_check_q) burst_q.push_back(make_xfer(1'b0, 1'b1, 8'h00));
      burst_q.push_back(make_xfer(rs, 1'b0, b));
    end else begin
      burst_q.push_back(make_xfer(rs, 1'b0, b & clws_pkg::HI_NIBBLE));
      burst_q.push_back(make_xfer(rs, 1'b0, {b[3:0], 4'h0}));
    end
  endtask

  // works out the bus transfers one accepted request causes
  task automatic predict_request(input clws_pkg::item_t req);
    clws_pkg::count_t cnt;
    logic [7:0]       pos;
    lcd_xfer_t        x;
    case (req.operation)
      clws_pkg::OP_TEXT: begin
        cnt = req.start_of_text ? '0 : text_count_q;
        queue_byte(1'b1, req.byte_value);
        cnt = cnt + 6'd1;
        if (cnt == clws_pkg::WRAP_LINE_TWO) begin
          queue_byte(1'b0, clws_pkg::CMD_LINE_TWO);
          line_two_wraps++;
        end else if (cnt == clws_pkg::WRAP_CLEAR) begin
          queue_byte(1'b0, clws_pkg::CMD_CLEAR);
          queue_byte(1'b0, clws_pkg::CMD_LINE_ONE);
          cnt = '0;
          clear_wraps++;
        end
        text_count_q = cnt;
      end
      clws_pkg::OP_CMD: queue_byte(1'b0, req.byte_value);
      clws_pkg::OP_MOVE: begin
        // only lines one and two, and columns inside the line, move the cursor
        if (req.line_number <= 2'd1 && req.column < clws_pkg::LINE_LENGTH) begin
          pos = (req.line_number == 2'd0) ? clws_pkg::CMD_LINE_ONE : clws_pkg::CMD_LINE_TWO;
          queue_byte(1'b0, pos | req.column);
        end
      end
      default: ;
    endcase
    for (int i = 0; i < burst_q.size(); i++) begin
      x = burst_q[i];
      x.last_transfer = (i == burst_q.size() - 1);
      expected_xfers.push_back(x);
    end
    burst_q.delete();
  endtask

  // offers one request, with an optional gap first, and waits for the transfer
  task automatic send_request(input clws_pkg::item_t req);
    if (gap_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= req.operation;
    in_ch.byte_value    <= req.byte_value;
    in_ch.start_of_text <= req.start_of_text;
    in_ch.line_number   <= req.line_number;
    in_ch.column        <= req.column;
    do @(posedge clk); while (!in_ch.ready);
    predict_request(req);
    requests_sent++;
  endtask

  // drains the block; requests with no transfer may still be in flight
  task automatic wait_for_idle();
    in_ch.valid <= 1'b0;
    while (expected_xfers.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_bus_config(input logic mode, input logic busy);
    wait_for_idle();
    cfg_we    <= 1'b1;
    cfg_index <= clws_pkg::CFG_BUS_MODE;
    cfg_data  <= mode;
    @(posedge clk);
    bus_mode_q = mode;
    cfg_index <= clws_pkg::CFG_BUSY_CHECK;
    cfg_data  <= busy;
    @(posedge clk);
    busy_check_q = busy;
    cfg_we <= 1'b0;
  endtask

  // field extremes, every request kind, invalid moves and the unused operation
  task automatic test_directed_requests();
    send_request(make_request(clws_pkg::OP_TEXT, 8'h00, 1'b1, 2'd0, 8'h00));
    send_request(make_request(clws_pkg::OP_TEXT, 8'hFF, 1'b0, 2'd3, 8'hFF));
    send_request(make_request(clws_pkg::OP_TEXT, 8'h5A, 1'b1, 2'd1, 8'h10));
    send_request(make_request(clws_pkg::OP_CMD, 8'h00, 1'b0, 2'd0, 8'h00));
    send_request(make_request(clws_pkg::OP_CMD, 8'hFF, 1'b0, 2'd3, 8'hFF));
    // start of text on a command must not restart the count
    send_request(make_request(clws_pkg::OP_CMD, clws_pkg::CMD_CLEAR, 1'b1, 2'd0, 8'h00));
    send_request(make_request(clws_pkg::OP_TEXT, 8'hA5, 1'b0, 2'd0, 8'h00));
    send_request(make_request(clws_pkg::OP_MOVE, 8'hFF, 1'b0, 2'd0, 8'd0));
    send_request(make_request(clws_pkg::OP_MOVE, 8'h00, 1'b1, 2'd0, 8'd15));
    send_request(make_request(clws_pkg::OP_MOVE, 8'h00, 1'b0, 2'd1, 8'd0));
    send_request(make_request(clws_pkg::OP_MOVE, 8'hFF, 1'b1, 2'd1, 8'd15));
    // invalid cursor moves emit nothing
    send_request(make_request(clws_pkg::OP_MOVE, 8'h00, 1'b0, 2'd2, 8'd3));
    send_request(make_request(clws_pkg::OP_MOVE, 8'h00, 1'b0, 2'd3, 8'd0));
    send_request(make_request(clws_pkg::OP_MOVE, 8'h00, 1'b0, 2'd0, 8'd16));
    send_request(make_request(clws_pkg::OP_MOVE, 8'h00, 1'b0, 2'd1, 8'd255));
    send_request(make_request(clws_pkg::OP_MOVE, 8'h00, 1'b0, 2'd0, 8'd128));
    // unused operation leaves the count alone
    send_request(make_request(OP_UNUSED, 8'hFF, 1'b1, 2'd3, 8'hFF));
    send_request(make_request(OP_UNUSED, 8'h00, 1'b0, 2'd0, 8'h00));
    send_request(make_request(clws_pkg::OP_TEXT, 8'h30, 1'b0, 2'd0, 8'h00));
  endtask

  // strings of random text with commands and moves mixed in, plus noise
  task automatic test_text_strings(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(1, 40);
        for (int k = 0; k < len && sent < n_items; k++) begin
          if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 1) == 0)
              send_request(make_request(clws_pkg::OP_CMD, 8'($urandom), 1'($urandom),
                                        2'($urandom), 8'($urandom)));
            else
              send_request(make_request(clws_pkg::OP_MOVE, 8'($urandom), 1'($urandom),
                                        2'($urandom_range(0, 1)),
                                        8'($urandom_range(0, clws_pkg::LINE_LENGTH - 1))));
            sent++;
          end
          send_request(make_request(clws_pkg::OP_TEXT, 8'($urandom), k == 0, 2'($urandom),
                                    8'($urandom)));
          sent++;
        end
      end else begin
        send_request(make_request(2'($urandom), 8'($urandom), 1'($urandom),
                                  2'($urandom), 8'($urandom)));
        sent++;
      end
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_output_stall();
    gap_en   = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++)
      send_request(make_request(clws_pkg::OP_TEXT, 8'($urandom), i == 0, 2'd0, 8'h00));
    gap_en = 1'b1;
  endtask

  // back-to-back traffic with neither side idling
  task automatic test_full_rate(input int n_items);
    gap_en   = 1'b0;
    stall_en = 1'b0;
    test_text_strings(n_items);
  endtask

  // receiver: random stall bursts and the long hold-off
  initial begin : receiver
    int n;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < HOLD_LEN) begin
          @(posedge clk);
          hold_cycles++;
        end
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 10);
        repeat (n) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // compare each bus transfer with the oldest prediction
  always @(posedge clk) begin : check_transfer
    lcd_xfer_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_xfers.size() == 0) begin
        $error("bus transfer with none expected: rs %0d rnw %0d bus 0x%02h last %0d",
               out_ch.register_select, out_ch.read_not_write, out_ch.bus_value,
               out_ch.last_transfer);
        mismatch_count++;
      end else begin
        want = expected_xfers.pop_front();
        xfers_checked++;
        if (out_ch.register_select !== want.register_select) begin
          $error("register_select: expected %0d, got %0d",
                 want.register_select, out_ch.register_select);
          mismatch_count++;
        end
        if (out_ch.read_not_write !== want.read_not_write) begin
          $error("read_not_write: expected %0d, got %0d",
                 want.read_not_write, out_ch.read_not_write);
          mismatch_count++;
        end
        if (out_ch.bus_value !== want.bus_value) begin
          $error("bus_value: expected 0x%02h, got 0x%02h", want.bus_value, out_ch.bus_value);
          mismatch_count++;
        end
        if (out_ch.last_transfer !== want.last_transfer) begin
          $error("last_transfer: expected %0d, got %0d",
                 want.last_transfer, out_ch.last_transfer);
          mismatch_count++;
        end
      end
    end
  end

  // cycle counter ends a hung run
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= 1'b0;
    cfg_data            <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= clws_pkg::OP_TEXT;
    in_ch.byte_value    <= 8'h00;
    in_ch.start_of_text <= 1'b0;
    in_ch.line_number   <= 2'd0;
    in_ch.column        <= 8'h00;
    bus_mode_q     = 1'b0;
    busy_check_q   = 1'b1;
    text_count_q   = '0;
    gap_en         = 1'b1;
    stall_en       = 1'b1;
    hold_req       = 1'b0;
    mismatch_count = 0;
    requests_sent  = 0;
    xfers_checked  = 0;
    line_two_wraps = 0;
    clear_wraps    = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // four-bit mode with busy check on, as after reset
    test_directed_requests();
    test_text_strings(80);
    write_bus_config(1'b1, 1'b1);
    test_output_stall();
    test_text_strings(80);
    write_bus_config(1'b1, 1'b0);
    test_text_strings(80);
    write_bus_config(1'b0, 1'b0);
    test_full_rate(80);

    in_ch.valid <= 1'b0;
    while (expected_xfers.size() != 0) @(posedge clk);
    repeat (2 * IDLE_SETTLE) @(posedge clk);
    if (expected_xfers.size() != 0) begin
      $error("%0d bus transfers never arrived", expected_xfers.size());
      mismatch_count += expected_xfers.size();
    end

    $display("%0d requests and %0d bus transfers checked in four- and eight-bit modes",
             requests_sent, xfers_checked);
    $display("wraps to line two: %0d, clear and home: %0d, mismatches: %0d",
             line_two_wraps, clear_wraps, mismatch_count);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/clws_pkg.sv
hw/rtl/clws_in_if.sv
hw/rtl/clws_out_if.sv
hw/rtl/clws_decode.sv
hw/rtl/clws_emit.sv
hw/rtl/char_lcd_write_sequencer.sv
verif/char_lcd_write_sequencer_test.sv
